FILE: src/cle_pkg.sv
// shared types, key codes and default sizing for the console line editor
package cle_pkg;

  localparam int LINE_DEPTH_DEFAULT = 128;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] COUNT_MAX  = 8'hff;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_CHAR  = 2'd1,
    ECHO_ERASE = 2'd2
  } echo_kind_e;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_CHAR  = 2'd1,
    RD_EOF   = 2'd2,
    RD_EMPTY = 2'd3
  } read_status_e;

  // what the decode step leaves to be done
  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_KILL   = 2'd1,
    CLS_READ   = 2'd2
  } item_class_e;

  typedef struct packed {
    logic take_item;
    logic decode;
    logic kill_step;
    logic read_finish;
    logic raddr_kill;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    item_class_e cls;
    logic        at_commit;
    logic        kill_stop;
    logic        out_free;
  } status_t;

endpackage

FILE: src/cle_ram.sv
// generic single write port, single read port ram with registered read
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cle_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/cle_datapath.sv
// ring indices, line store, result staging and output register
module cle_datapath #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cle_pkg::cmd_t    cmd_i,
  output cle_pkg::status_t status_o,
  input  logic             op_i,
  input  logic [7:0]       key_code_i,
  input  logic             first_of_request_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       echo_kind_o,
  output logic [7:0]       echo_char_o,
  output logic [7:0]       erase_count_o,
  output logic             line_committed_o,
  output logic             dump_request_o,
  output logic [1:0]       read_status_o,
  output logic [7:0]       read_char_o
);

  localparam int IDX_MOD = 2 * LINE_DEPTH;
  localparam int IW      = $clog2(IDX_MOD);
  localparam int SW      = $clog2(LINE_DEPTH);

  localparam logic [IW-1:0] IDX_LAST = IW'(IDX_MOD - 1);
  localparam logic [IW-1:0] IDX_DEPTH = IW'(LINE_DEPTH);

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] x);
    return (x == IDX_LAST) ? '0 : x + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] x);
    return (x == '0) ? IDX_LAST : x - IW'(1);
  endfunction

  function automatic logic [SW-1:0] slot(input logic [IW-1:0] x);
    logic [IW-1:0] t;
    t = (x >= IDX_DEPTH) ? x - IDX_DEPTH : x;
    return t[SW-1:0];
  endfunction

  function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] w;
    w = (a >= b) ? {1'b0, a} - {1'b0, b}
                 : {1'b0, a} + (IW+1)'(IDX_MOD) - {1'b0, b};
    return w[IW-1:0];
  endfunction

  // latched item
  logic       op_q, op_d;
  logic [7:0] key_q, key_d;
  logic       first_q, first_d;

  // ring indices
  logic [IW-1:0] read_q, read_d;
  logic [IW-1:0] commit_q, commit_d;
  logic [IW-1:0] edit_q, edit_d;

  // result staging
  cle_pkg::echo_kind_e   res_kind_q, res_kind_d;
  logic [7:0]            res_echo_q, res_echo_d;
  logic [7:0]            res_erase_q, res_erase_d;
  logic                  res_commit_q, res_commit_d;
  logic                  res_dump_q, res_dump_d;
  cle_pkg::read_status_e res_rstat_q, res_rstat_d;
  logic [7:0]            res_rchar_q, res_rchar_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  cle_pkg::echo_kind_e   out_kind_q, out_kind_d;
  logic [7:0]            out_echo_q, out_echo_d;
  logic [7:0]            out_erase_q, out_erase_d;
  logic                  out_commit_q, out_commit_d;
  logic                  out_dump_q, out_dump_d;
  cle_pkg::read_status_e out_rstat_q, out_rstat_d;
  logic [7:0]            out_rchar_q, out_rchar_d;

  logic          ram_we;
  logic [SW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    key_mapped;
  logic [IW-1:0] edit_next;
  logic          has_room;
  logic          is_erase_key;

  assign key_mapped   = (key_q == cle_pkg::KEY_CR) ? cle_pkg::KEY_LF : key_q;
  assign edit_next    = idx_next(edit_q);
  assign has_room     = idx_dist(edit_q, read_q) < IDX_DEPTH;
  assign is_erase_key = (key_q == cle_pkg::KEY_CTRL_H) || (key_q == cle_pkg::KEY_DEL);

  // store write happens only in the decode cycle of a storable key
  assign ram_we = cmd_i.decode && (op_q == cle_pkg::OP_KEY) &&
                  (key_q != cle_pkg::KEY_CTRL_P) && (key_q != cle_pkg::KEY_CTRL_U) &&
                  !is_erase_key && (key_q != cle_pkg::KEY_NUL) && has_room;

  assign ram_raddr = cmd_i.raddr_kill ? slot(idx_prev(edit_q)) : slot(read_q);

  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot(edit_q)),
    .wdata_i (key_mapped),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (op_q == cle_pkg::OP_READ) begin
      status_o.cls = (read_q == commit_q) ? cle_pkg::CLS_SIMPLE : cle_pkg::CLS_READ;
    end else if (key_q == cle_pkg::KEY_CTRL_U) begin
      status_o.cls = cle_pkg::CLS_KILL;
    end else begin
      status_o.cls = cle_pkg::CLS_SIMPLE;
    end
    status_o.at_commit = (edit_q == commit_q);
    status_o.kill_stop = (ram_rdata == cle_pkg::KEY_LF);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    first_d      = first_q;
    read_d       = read_q;
    commit_d     = commit_q;
    edit_d       = edit_q;
    res_kind_d   = res_kind_q;
    res_echo_d   = res_echo_q;
    res_erase_d  = res_erase_q;
    res_commit_d = res_commit_q;
    res_dump_d   = res_dump_q;
    res_rstat_d  = res_rstat_q;
    res_rchar_d  = res_rchar_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_echo_d   = out_echo_q;
    out_erase_d  = out_erase_q;
    out_commit_d = out_commit_q;
    out_dump_d   = out_dump_q;
    out_rstat_d  = out_rstat_q;
    out_rchar_d  = out_rchar_q;

    if (cmd_i.take_item) begin
      op_d    = op_i;
      key_d   = key_code_i;
      first_d = first_of_request_i;
    end

    if (cmd_i.decode) begin
      res_kind_d   = cle_pkg::ECHO_NONE;
      res_echo_d   = '0;
      res_erase_d  = '0;
      res_commit_d = 1'b0;
      res_dump_d   = 1'b0;
      res_rstat_d  = cle_pkg::RD_NONE;
      res_rchar_d  = '0;
      if (op_q == cle_pkg::OP_READ) begin
        if (read_q == commit_q) begin
          res_rstat_d = cle_pkg::RD_EMPTY;
        end
      end else if (key_q == cle_pkg::KEY_CTRL_P) begin
        res_dump_d = 1'b1;
      end else if (key_q == cle_pkg::KEY_CTRL_U) begin
        // the walk follows in kill steps
      end else if (is_erase_key) begin
        if (edit_q != commit_q) begin
          edit_d      = idx_prev(edit_q);
          res_kind_d  = cle_pkg::ECHO_ERASE;
          res_erase_d = 8'd1;
        end
      end else if (ram_we) begin
        edit_d     = edit_next;
        res_kind_d = cle_pkg::ECHO_CHAR;
        res_echo_d = key_mapped;
        if ((key_mapped == cle_pkg::KEY_LF) || (key_mapped == cle_pkg::KEY_CTRL_D) ||
            (idx_dist(edit_next, read_q) == IDX_DEPTH)) begin
          commit_d     = edit_next;
          res_commit_d = 1'b1;
        end
      end
    end

    if (cmd_i.kill_step) begin
      edit_d     = idx_prev(edit_q);
      res_kind_d = cle_pkg::ECHO_ERASE;
      if (res_erase_q != cle_pkg::COUNT_MAX) begin
        res_erase_d = res_erase_q + 8'd1;
      end
    end

    if (cmd_i.read_finish) begin
      if (ram_rdata == cle_pkg::KEY_CTRL_D) begin
        res_rstat_d = cle_pkg::RD_EOF;
        if (first_q) begin
          read_d = idx_next(read_q);
        end
      end else begin
        res_rstat_d = cle_pkg::RD_CHAR;
        res_rchar_d = ram_rdata;
        read_d      = idx_next(read_q);
      end
    end

    if (cmd_i.out_load) begin
      out_valid_d  = 1'b1;
      out_kind_d   = res_kind_q;
      out_echo_d   = res_echo_q;
      out_erase_d  = res_erase_q;
      out_commit_d = res_commit_q;
      out_dump_d   = res_dump_q;
      out_rstat_d  = res_rstat_q;
      out_rchar_d  = res_rchar_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q      <= '0;
      commit_q    <= '0;
      edit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      read_q      <= read_d;
      commit_q    <= commit_d;
      edit_q      <= edit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    first_q      <= first_d;
    res_kind_q   <= res_kind_d;
    res_echo_q   <= res_echo_d;
    res_erase_q  <= res_erase_d;
    res_commit_q <= res_commit_d;
    res_dump_q   <= res_dump_d;
    res_rstat_q  <= res_rstat_d;
    res_rchar_q  <= res_rchar_d;
    out_kind_q   <= out_kind_d;
    out_echo_q   <= out_echo_d;
    out_erase_q  <= out_erase_d;
    out_commit_q <= out_commit_d;
    out_dump_q   <= out_dump_d;
    out_rstat_q  <= out_rstat_d;
    out_rchar_q  <= out_rchar_d;
  end

  assign out_valid_o      = out_valid_q;
  assign echo_kind_o      = out_kind_q;
  assign echo_char_o      = out_echo_q;
  assign erase_count_o    = out_erase_q;
  assign line_committed_o = out_commit_q;
  assign dump_request_o   = out_dump_q;
  assign read_status_o    = out_rstat_q;
  assign read_char_o      = out_rchar_q;

endmodule

FILE: src/cle_ctrl.sv
// sequencer for item decode, kill-line walk, store read and result hand-off
module cle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cle_pkg::status_t status_i,
  output cle_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_KILL_ISSUE,
    ST_KILL_CHECK,
    ST_RD_DATA,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take_item = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        case (status_i.cls)
          cle_pkg::CLS_KILL: state_d = ST_KILL_ISSUE;
          cle_pkg::CLS_READ: state_d = ST_RD_DATA;
          default:           state_d = ST_FINISH;
        endcase
      end
      ST_KILL_ISSUE: begin
        cmd_o.raddr_kill = 1'b1;
        state_d = status_i.at_commit ? ST_FINISH : ST_KILL_CHECK;
      end
      ST_KILL_CHECK: begin
        if (status_i.kill_stop) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.kill_step = 1'b1;
          state_d = ST_KILL_ISSUE;
        end
      end
      ST_RD_DATA: begin
        cmd_o.read_finish = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/console_line_editor_core.sv
// top level of the console line editor: cooked-mode input ring with echo and reads
//
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   tuser: op; tdata: key_code, first_of_request
//  m_axis   out  m_axis_tvalid/tready   tuser: echo_kind, read_status; tdata: the rest
//
// a key or an empty read goes from decode straight to result hand-off; a read that returns
// a character or end of file first waits on the registered store read, and ctrl-u erases
// back to the commit index or a newline, each step waiting on the registered store read
// reset clears the three ring indices and the output register; the store needs no clear
// a result waits in the output register while the next item is taken and decoded;
// the hand-off of that next result stalls until the output register is free
module console_line_editor_core #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] key_code, [8] first_of_request, rest zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] op
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] echo_char, [15:8] erase_count,
                                        // [16] line_committed, [17] dump_request,
                                        // [25:18] read_char, rest zero
  output logic [3:0]  m_axis_tuser_o    // [1:0] echo_kind, [3:2] read_status
);

  cle_pkg::cmd_t    cmd;
  cle_pkg::status_t status;

  logic [1:0] echo_kind;
  logic [7:0] echo_char;
  logic [7:0] erase_count;
  logic       line_committed;
  logic       dump_request;
  logic [1:0] read_status;
  logic [7:0] read_char;

  // sequencer: one item at a time, from transfer through result hand-off
  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // indices, store and result registers
  cle_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .op_i               (s_axis_tuser_i[0]),
    .key_code_i         (s_axis_tdata_i[7:0]),
    .first_of_request_i (s_axis_tdata_i[8]),
    .out_ready_i        (m_axis_tready_i),
    .out_valid_o        (m_axis_tvalid_o),
    .echo_kind_o        (echo_kind),
    .echo_char_o        (echo_char),
    .erase_count_o      (erase_count),
    .line_committed_o   (line_committed),
    .dump_request_o     (dump_request),
    .read_status_o      (read_status),
    .read_char_o        (read_char)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata_o = {6'd0, read_char, dump_request, line_committed,
                           erase_count, echo_char};
  assign m_axis_tuser_o = {read_status, echo_kind};

endmodule

FILE: bench/tb.sv
// self-checking bench for the console line editor: edit/read traffic against a line predictor
`timescale 1ns / 100ps

module tb;
  import cle_pkg::*;

  localparam int LD         = LINE_DEPTH_DEFAULT;
  localparam int PW         = $clog2(2 * LD);
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 1200;

  typedef logic [PW-1:0] ptr_t;

  typedef struct packed {
    echo_kind_e   echo_kind;
    logic [7:0]   echo_char;
    logic [7:0]   erase_count;
    logic         line_committed;
    logic         dump_request;
    read_status_e read_status;
    logic [7:0]   read_char;
  } line_result_t;

  typedef struct packed {
    logic         op;
    logic [7:0]   key;
    logic         first;
    bit           typed;
    line_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic [0:0]  s_user = '0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [31:0] m_data;
  wire  [3:0]  m_user;

  console_line_editor_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state: ring contents and the three indices
  logic [7:0] ring_mem [LD];
  ptr_t       rd_ptr, commit_ptr, edit_ptr;

  line_result_t pending_results[$];
  stim_row_t    stim_table[$];
  bit           cur_typed = 1'b0;
  line_result_t cur_want;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int hold_req = 0;
  int n_commits = 0, n_drops = 0, n_eof = 0, n_empty = 0, n_dumps = 0, max_kill = 0;

  function automatic line_result_t make_result(echo_kind_e ek, logic [7:0] ec, logic [7:0] er,
                                               logic lc, logic dp, read_status_e rs,
                                               logic [7:0] rc);
    line_result_t r;
    r.echo_kind      = ek;
    r.echo_char      = ec;
    r.erase_count    = er;
    r.line_committed = lc;
    r.dump_request   = dp;
    r.read_status    = rs;
    r.read_char      = rc;
    return r;
  endfunction

  function automatic logic [PW-2:0] slot_of(ptr_t p);
    return p[PW-2:0];
  endfunction

  // one item against the ring, updating the copy of the indices
  function automatic line_result_t predict_line_edit(logic op, logic [7:0] key, logic first);
    line_result_t r;
    logic [7:0]   c;
    ptr_t         fill;
    int           n;
    r = make_result(ECHO_NONE, 8'h00, 8'h00, 1'b0, 1'b0, RD_NONE, 8'h00);
    n = 0;
    if (op == OP_KEY) begin
      if (key == KEY_CTRL_P) begin
        r.dump_request = 1'b1;
        n_dumps++;
      end else if (key == KEY_CTRL_U) begin
        while (edit_ptr != commit_ptr && ring_mem[slot_of(edit_ptr - 1'b1)] != KEY_LF) begin
          edit_ptr = edit_ptr - 1'b1;
          n++;
        end
        if (n > 0) begin
          r.echo_kind   = ECHO_ERASE;
          r.erase_count = (n > 255) ? COUNT_MAX : n[7:0];
        end
        if (n > max_kill) max_kill = n;
      end else if (key == KEY_CTRL_H || key == KEY_DEL) begin
        if (edit_ptr != commit_ptr) begin
          edit_ptr      = edit_ptr - 1'b1;
          r.echo_kind   = ECHO_ERASE;
          r.erase_count = 8'd1;
        end
      end else if (key != KEY_NUL) begin
        fill = edit_ptr - rd_ptr;
        if (fill < LD) begin
          c = (key == KEY_CR) ? KEY_LF : key;
          ring_mem[slot_of(edit_ptr)] = c;
          edit_ptr    = edit_ptr + 1'b1;
          r.echo_kind = ECHO_CHAR;
          r.echo_char = c;
          fill = edit_ptr - rd_ptr;
          if (c == KEY_LF || c == KEY_CTRL_D || fill == LD) begin
            commit_ptr       = edit_ptr;
            r.line_committed = 1'b1;
            n_commits++;
          end
        end else begin
          n_drops++;
        end
      end
    end else begin
      if (rd_ptr == commit_ptr) begin
        r.read_status = RD_EMPTY;
        n_empty++;
      end else begin
        c = ring_mem[slot_of(rd_ptr)];
        if (c == KEY_CTRL_D) begin
          r.read_status = RD_EOF;
          n_eof++;
          if (first) rd_ptr = rd_ptr + 1'b1;
        end else begin
          r.read_status = RD_CHAR;
          r.read_char   = c;
          rd_ptr        = rd_ptr + 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // predict on every input transfer, compare on every output transfer, watch for a hang
  always @(posedge clk) begin : monitor
    line_result_t want_r, got_r;
    if (rst_n) begin
      if (s_valid && s_ready) begin
        want_r = predict_line_edit(s_user[0], s_data[7:0], s_data[8]);
        if (cur_typed) want_r = cur_want;
        pending_results.push_back(want_r);
      end
      if (m_valid && m_ready) begin
        got_r.echo_kind      = echo_kind_e'(m_user[1:0]);
        got_r.read_status    = read_status_e'(m_user[3:2]);
        got_r.echo_char      = m_data[7:0];
        got_r.erase_count    = m_data[15:8];
        got_r.line_committed = m_data[16];
        got_r.dump_request   = m_data[17];
        got_r.read_char      = m_data[25:18];
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result transfer with no item outstanding, expected none, actual %h_%h",
                   $time, m_user, m_data);
          errors++;
        end else begin
          want_r = pending_results.pop_front();
          check_field("echo_kind", want_r.echo_kind, got_r.echo_kind);
          check_field("echo_char", want_r.echo_char, got_r.echo_char);
          check_field("erase_count", want_r.erase_count, got_r.erase_count);
          check_field("line_committed", want_r.line_committed, got_r.line_committed);
          check_field("dump_request", want_r.dump_request, got_r.dump_request);
          check_field("read_status", want_r.read_status, got_r.read_status);
          check_field("read_char", want_r.read_char, got_r.read_char);
        end
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random back-pressure, long holds on request, stretches always ready
  initial begin : receiver
    int hold_cnt, fast_cnt, r;
    hold_cnt = 0;
    fast_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        m_ready = 1'b0;
        hold_cnt--;
      end else if (fast_cnt > 0) begin
        m_ready = 1'b1;
        fast_cnt--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_ready = 1'b1;
        end else if (r < 85) begin
          m_ready  = 1'b0;
          hold_cnt = $urandom_range(0, 3);
        end else if (r < 88) begin
          m_ready  = 1'b0;
          hold_cnt = $urandom_range(20, 80);
        end else begin
          m_ready  = 1'b1;
          fast_cnt = $urandom_range(30, 150);
        end
      end
    end
  end

  // offer one item until it is taken, then maybe leave a gap
  task automatic send_item(logic op, logic [7:0] key, logic first, bit typed,
                           line_result_t want);
    int g, r;
    @(negedge clk);
    s_valid   = 1'b1;
    s_user    = op;
    s_data    = {7'b0, first, key};
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (!s_ready);
    items_sent++;
    g = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) g = 0;
      else if (r < 85) g = $urandom_range(1, 3);
      else if (r < 88) g = $urandom_range(20, 60);
      else burst_left = $urandom_range(20, 100);
    end
    if (g > 0) begin
      @(negedge clk);
      s_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send(logic op, logic [7:0] key, logic first);
    send_item(op, key, first, 1'b0, make_result(ECHO_NONE, 0, 0, 0, 0, RD_NONE, 0));
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain();
    @(negedge clk);
    s_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(logic op, logic [7:0] key, logic first, bit typed,
                         line_result_t want);
    stim_row_t row;
    row.op    = op;
    row.key   = key;
    row.first = first;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return c;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    line_result_t none;
    int           sc, len, k, r2, dir_count;
    bit           hold_done, pause_done;
    logic [7:0]   ch;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    none = make_result(ECHO_NONE, 0, 0, 0, 0, RD_NONE, 0);
    for (k = 0; k < LD; k++) ring_mem[k] = 8'h00;
    rd_ptr     = '0;
    commit_ptr = '0;
    edit_ptr   = '0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed part: empty ring, special keys, edits, commit, eof semantics
    add_row(OP_READ, 8'h00, 1'b1, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 0, RD_EMPTY, 0));
    add_row(OP_KEY, KEY_NUL, 1'b0, 1'b1, none);
    add_row(OP_KEY, KEY_CTRL_P, 1'b1, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 1, RD_NONE, 0));
    add_row(OP_KEY, KEY_CTRL_H, 1'b0, 1'b1, none);
    add_row(OP_KEY, KEY_CTRL_U, 1'b0, 1'b1, none);
    add_row(OP_KEY, 8'h61, 1'b1, 1'b1, make_result(ECHO_CHAR, 8'h61, 0, 0, 0, RD_NONE, 0));
    add_row(OP_KEY, 8'hff, 1'b0, 1'b1, make_result(ECHO_CHAR, 8'hff, 0, 0, 0, RD_NONE, 0));
    add_row(OP_KEY, 8'h80, 1'b0, 1'b0, none);
    add_row(OP_KEY, KEY_DEL, 1'b0, 1'b1, make_result(ECHO_ERASE, 0, 1, 0, 0, RD_NONE, 0));
    add_row(OP_KEY, 8'h01, 1'b0, 1'b0, none);
    add_row(OP_KEY, KEY_CTRL_U, 1'b1, 1'b0, none);
    add_row(OP_KEY, 8'h62, 1'b0, 1'b0, none);
    add_row(OP_KEY, KEY_CR, 1'b0, 1'b1, make_result(ECHO_CHAR, KEY_LF, 0, 1, 0, RD_NONE, 0));
    add_row(OP_READ, 8'hff, 1'b1, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 0, RD_CHAR, 8'h62));
    add_row(OP_READ, 8'h00, 1'b0, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 0, RD_CHAR, KEY_LF));
    add_row(OP_READ, 8'h00, 1'b0, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 0, RD_EMPTY, 0));
    add_row(OP_KEY, KEY_CTRL_D, 1'b0, 1'b1,
            make_result(ECHO_CHAR, KEY_CTRL_D, 0, 1, 0, RD_NONE, 0));
    add_row(OP_READ, 8'h00, 1'b0, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 0, RD_EOF, 0));
    add_row(OP_READ, 8'h55, 1'b0, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 0, RD_EOF, 0));
    add_row(OP_READ, 8'h00, 1'b1, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 0, RD_EOF, 0));
    add_row(OP_READ, 8'h00, 1'b1, 1'b1, make_result(ECHO_NONE, 0, 0, 0, 0, RD_EMPTY, 0));
    add_row(OP_KEY, KEY_LF, 1'b0, 1'b1, make_result(ECHO_CHAR, KEY_LF, 0, 1, 0, RD_NONE, 0));
    add_row(OP_KEY, KEY_CTRL_H, 1'b0, 1'b1, none);
    add_row(OP_READ, 8'haa, 1'b1, 1'b0, none);
    foreach (stim_table[i])
      send_item(stim_table[i].op, stim_table[i].key, stim_table[i].first,
                stim_table[i].typed, stim_table[i].want);
    dir_count = items_sent;
    drain();

    // random part: mostly typed lines and read bursts, some long lines and noise
    while (items_sent < dir_count + RAND_ITEMS) begin
      sc = $urandom_range(0, 99);
      if (sc < 40) begin
        len = $urandom_range(0, 12);
        for (k = 0; k < len; k++) begin
          r2 = $urandom_range(0, 99);
          if (r2 < 75) ch = text_char();
          else if (r2 < 85) ch = rand_bit() ? KEY_CTRL_H : KEY_DEL;
          else if (r2 < 88) ch = KEY_CTRL_U;
          else ch = rand_byte();
          send(OP_KEY, ch, rand_bit());
        end
        r2 = $urandom_range(0, 99);
        if (r2 < 60) send(OP_KEY, KEY_LF, rand_bit());
        else if (r2 < 85) send(OP_KEY, KEY_CR, rand_bit());
        else if (r2 < 92) send(OP_KEY, KEY_CTRL_D, rand_bit());
      end else if (sc < 65) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++)
          send(OP_READ, rand_byte(), (k == 0) || ($urandom_range(0, 3) == 0));
      end else if (sc < 70) begin
        // long unterminated line: ring full, dropped keys, long kill walks
        len = $urandom_range(60, 135);
        for (k = 0; k < len; k++) send(OP_KEY, text_char(), 1'b0);
        r2 = $urandom_range(0, 2);
        if (r2 == 0) send(OP_KEY, KEY_CTRL_U, 1'b0);
        else if (r2 == 1) send(OP_KEY, KEY_DEL, 1'b0);
        else send(OP_KEY, KEY_LF, 1'b0);
      end else if (sc < 75) begin
        send(OP_KEY, KEY_CTRL_D, 1'b0);
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) send(OP_READ, rand_byte(), 1'b0);
        send(OP_READ, rand_byte(), 1'b1);
      end else if (sc < 87) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++)
          send(rand_bit(), rand_byte(), rand_bit());
      end else if (sc < 93) begin
        len = $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
          r2 = $urandom_range(0, 4);
          case (r2)
            0: ch = KEY_CTRL_P;
            1: ch = KEY_CTRL_U;
            2: ch = KEY_CTRL_H;
            3: ch = KEY_DEL;
            default: ch = KEY_NUL;
          endcase
          send(OP_KEY, ch, rand_bit());
        end
      end else begin
        len = $urandom_range(20, 140);
        for (k = 0; k < len; k++)
          send(OP_READ, rand_byte(), rand_bit());
      end

      // output held off for a long time while items keep coming
      if (!hold_done && items_sent > dir_count + 400) begin
        hold_req  = 300;
        hold_done = 1'b1;
      end
      // sender quiet until everything is back
      if (!pause_done && items_sent > dir_count + 800) begin
        drain();
        pause_done = 1'b1;
      end
    end

    drain();
    // wait past the longest kill walk; catch any stray result
    repeat (300) @(posedge clk);

    $display("run: %0d items, %0d results checked, %0d commits, %0d keys dropped on a full ring",
             items_sent, results_seen, n_commits, n_drops);
    $display("run: %0d eof reads, %0d empty reads, %0d dump requests, longest kill %0d chars",
             n_eof, n_empty, n_dumps, max_kill);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cle_pkg.sv
src/cle_ram.sv
src/cle_datapath.sv
src/cle_ctrl.sv
src/console_line_editor_core.sv
bench/tb.sv
